// File: rtl/core/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// shared constants and filter tap tables for the adpcm block decoder
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

  localparam int BLOCK_INDEX_BITS_DEF = 15;
  localparam int DATA_BYTES           = 14;
  localparam int BLOCK_BYTES          = DATA_BYTES + 2;
  localparam int POS_BITS             = $clog2(BLOCK_BYTES);

  localparam logic [POS_BITS-1:0] POS_HEADER = POS_BITS'(0);
  localparam logic [POS_BITS-1:0] POS_FLAGS  = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_LAST   = POS_BITS'(DATA_BYTES + 1);

  localparam logic OP_STREAM  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam int FLAG_END    = 0;
  localparam int FLAG_REPEAT = 1;
  localparam int FLAG_LOOP   = 2;

  localparam logic [3:0] FILTER_MAX = 4'd4;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  localparam int ACC_BITS = 24;
  localparam int SUM_BITS = 20;
  localparam int PRED_SHIFT = 6;

  function automatic logic signed [7:0] tap_pos(input logic [2:0] filter);
    logic signed [7:0] tap;
    case (filter)
      3'd1:    tap = 8'sd60;
      3'd2:    tap = 8'sd115;
      3'd3:    tap = 8'sd98;
      3'd4:    tap = 8'sd122;
      default: tap = 8'sd0;
    endcase
    return tap;
  endfunction

  function automatic logic signed [7:0] tap_neg(input logic [2:0] filter);
    logic signed [7:0] tap;
    case (filter)
      3'd2:    tap = -8'sd52;
      3'd3:    tap = -8'sd55;
      3'd4:    tap = -8'sd60;
      default: tap = 8'sd0;
    endcase
    return tap;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/adpcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// adpcm_block_decoder_unit
// byte-serial decoder for 16-byte adpcm sound blocks with loop tracking
// ----------------------------------------------------------------------------
// Feed one stream byte per item. Header bytes and restart items leave the input
// ready. A data byte of a running block gives two samples, each formed on one
// shared 16x8 multiplier in states MUL1, MUL2 and FIN (first tap product, second
// tap product plus accumulate, shift and clamp) and then handed to the output
// register in EMIT; the input stays not ready until both samples are handed on.
// The last byte of a stopping block instead sends a stop item through EMIT and
// keeps the input not ready until it is handed on. The output register lets the
// next sample be computed while the previous one waits.
// block_last marks the final item of a block together with the next block index
// to fetch, or stopped when the channel halts; a halted channel ignores stream
// bytes until a restart item.
`default_nettype none

module adpcm_block_decoder_unit #(
  parameter int BLOCK_INDEX_BITS = abd_pkg::BLOCK_INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        opcode,
  input  wire logic [7:0]                  data_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [15:0]               sample,
  output logic                             sample_valid,
  output logic                             block_last,
  output logic [BLOCK_INDEX_BITS-1:0]      next_block,
  output logic                             stopped
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam int PB = abd_pkg::POS_BITS;
  localparam int AB = abd_pkg::ACC_BITS;
  localparam int SB = abd_pkg::SUM_BITS;

  logic [2:0]                  state;
  logic [PB-1:0]               byte_count;
  logic signed [15:0]          hist_one;
  logic signed [15:0]          hist_two;
  logic signed [15:0]          loop_hist_one;
  logic signed [15:0]          loop_hist_two;
  logic [BLOCK_INDEX_BITS-1:0] block_index;
  logic [BLOCK_INDEX_BITS-1:0] loop_index;
  logic [2:0]                  filter_sel;
  logic [3:0]                  shift_amount;
  logic [2:0]                  flag_bits;
  logic                        halted;

  logic                        second;
  logic                        last_byte;
  logic [3:0]                  cur_nib;
  logic [3:0]                  hi_nib;
  logic signed [AB-1:0]        acc;

  logic signed [15:0]          res_sample;
  logic                        res_valid;
  logic                        res_last;
  logic [BLOCK_INDEX_BITS-1:0] res_next;
  logic                        res_stop;

  logic                        accept;
  logic                        out_free;
  logic                        stopping;
  logic [PB-1:0]               pos;
  logic signed [15:0]          mul_a;
  logic signed [7:0]           mul_b;
  logic signed [AB-1:0]        product;
  logic signed [15:0]          nib_term;
  logic signed [15:0]          nib_shifted;
  logic signed [SB-1:0]        sum;
  logic signed [15:0]          clamped;
  logic [BLOCK_INDEX_BITS-1:0] block_index_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign pos      = byte_count;
  assign stopping = flag_bits[abd_pkg::FLAG_END] && !flag_bits[abd_pkg::FLAG_REPEAT];

  // shared multiplier
  assign mul_a   = (state == S_MUL1) ? hist_one : hist_two;
  assign mul_b   = (state == S_MUL1) ? abd_pkg::tap_pos(filter_sel)
                                     : abd_pkg::tap_neg(filter_sel);
  assign product = AB'(mul_a) * AB'(mul_b);

  assign nib_term    = $signed({cur_nib, 12'd0});
  assign nib_shifted = nib_term >>> shift_amount;
  assign sum         = SB'(acc >>> abd_pkg::PRED_SHIFT) + SB'(nib_shifted);

  always_comb begin
    if (sum > SB'(abd_pkg::SAMPLE_MAX)) begin
      clamped = 16'(abd_pkg::SAMPLE_MAX);
    end else if (sum < SB'(abd_pkg::SAMPLE_MIN)) begin
      clamped = 16'(abd_pkg::SAMPLE_MIN);
    end else begin
      clamped = sum[15:0];
    end
  end

  always_comb begin
    if (flag_bits[abd_pkg::FLAG_END]) begin
      block_index_next = loop_index;
    end else begin
      block_index_next = block_index + BLOCK_INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && opcode == abd_pkg::OP_RESTART)) begin
      byte_count    <= '0;
      hist_one      <= '0;
      hist_two      <= '0;
      loop_hist_one <= '0;
      loop_hist_two <= '0;
      block_index   <= '0;
      loop_index    <= '0;
      filter_sel    <= '0;
      shift_amount  <= '0;
      flag_bits     <= '0;
      halted        <= 1'b0;
    end else begin
      if (accept && !halted) begin
        byte_count <= (pos == abd_pkg::POS_LAST) ? '0 : pos + PB'(1);
        unique case (pos)
          abd_pkg::POS_HEADER: begin
            shift_amount <= data_byte[3:0];
            filter_sel   <= (data_byte[7:4] > abd_pkg::FILTER_MAX) ? 3'd0 : data_byte[6:4];
          end
          abd_pkg::POS_FLAGS: begin
            flag_bits <= data_byte[2:0];
            if (data_byte[abd_pkg::FLAG_LOOP]) begin
              loop_index    <= block_index;
              loop_hist_one <= hist_one;
              loop_hist_two <= hist_two;
            end
          end
          default: begin
            if (pos == abd_pkg::POS_LAST) begin
              if (stopping) begin
                halted <= 1'b1;
              end
            end
          end
        endcase
      end
      if (state == S_FIN) begin
        if (second && last_byte) begin
          block_index <= block_index_next;
          if (flag_bits[abd_pkg::FLAG_END]) begin
            hist_one <= loop_hist_one;
            hist_two <= loop_hist_two;
          end else begin
            hist_one <= clamped;
            hist_two <= hist_one;
          end
        end else begin
          hist_one <= clamped;
          hist_two <= hist_one;
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && opcode == abd_pkg::OP_STREAM && !halted &&
              pos != abd_pkg::POS_HEADER && pos != abd_pkg::POS_FLAGS) begin
            if (stopping) begin
              if (pos == abd_pkg::POS_LAST) begin
                state  <= S_EMIT;
                second <= 1'b1;
              end
            end else begin
              state  <= S_MUL1;
              second <= 1'b0;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_FIN;
        S_FIN:  state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            if (second) begin
              state <= S_IDLE;
            end else begin
              state  <= S_MUL1;
              second <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur_nib    <= data_byte[3:0];
        hi_nib     <= data_byte[7:4];
        last_byte  <= (pos == abd_pkg::POS_LAST);
        res_sample <= '0;
        res_valid  <= 1'b0;
        res_last   <= 1'b1;
        res_next   <= block_index;
        res_stop   <= 1'b1;
      end
      S_MUL1: acc <= product;
      S_MUL2: acc <= acc + product;
      S_FIN: begin
        res_sample <= clamped;
        res_valid  <= 1'b1;
        res_last   <= second && last_byte;
        res_next   <= (second && last_byte) ? block_index_next : '0;
        res_stop   <= 1'b0;
      end
      S_EMIT: begin
        if (out_free) begin
          cur_nib <= hi_nib;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      sample       <= res_sample;
      sample_valid <= res_valid;
      block_last   <= res_last;
      next_block   <= res_next;
      stopped      <= res_stop;
    end
  end

  a_stop_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stopped) |-> (block_last && !sample_valid && sample == 16'sd0))
    else $error("stop item must be a block end with no sample");

  a_halt_aligned: assert property (@(posedge clk) disable iff (rst)
    halted |-> (byte_count == '0))
    else $error("halted channel not at block start");

  a_fin_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (state == S_EMIT))
    else $error("sequencer skipped emit after finish");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL1) |=> (state == S_MUL2 && !in_ready))
    else $error("multiply sequence broken");

  a_last_has_sample: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_last && !stopped) |-> sample_valid)
    else $error("block end without sample on a running channel");

endmodule

`default_nettype wire
